// ===== hdl/tdpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    // Datapath widths
    localparam int VALUE_W = 32;              // width of the tested number (even)
    localparam int ROOT_W  = VALUE_W / 2;     // width of the floor square root
    localparam int DIV_W   = ROOT_W + 1;      // trial divisor reaches root + 1
    localparam int CNT_W   = $clog2(VALUE_W); // iteration counter
    localparam int PC_W    = 3;

    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(VALUE_W - 1);
    localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(2);

    // Microprogram addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
    localparam logic [PC_W-1:0] PC_SQRT     = 3'd1;
    localparam logic [PC_W-1:0] PC_CHECK    = 3'd2;
    localparam logic [PC_W-1:0] PC_TEST_D   = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV      = 3'd4;
    localparam logic [PC_W-1:0] PC_NEXT_D   = 3'd5;
    localparam logic [PC_W-1:0] PC_COMPOSITE = 3'd6;
    localparam logic [PC_W-1:0] PC_PRIME    = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,      // capture the number, seed the square root
        OP_SQRT,      // one square-root step (two bits)
        OP_SET_D,     // first trial divisor
        OP_DIV_INIT,  // clear partial remainder, load dividend
        OP_DIV,       // one restoring-division step
        OP_NEXT_D     // advance trial divisor
    } t_op;

    // Jump conditions; a true condition jumps to the target, else falls through
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_SQRT_RUN,
        C_BELOW_TWO,
        C_D_PAST_ROOT,
        C_DIV_RUN,
        C_REM_NZ
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            strobe;
        logic            prime;
    } t_ctrl;

    // Control store
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl cw;
        cw = '{op: OP_NONE, cond: C_NEVER, target: PC_IDLE, strobe: 1'b0, prime: 1'b0};
        case (pc)
            PC_IDLE: begin
                cw.op = OP_LOAD;     cw.cond = C_NO_START;    cw.target = PC_IDLE;
            end
            PC_SQRT: begin
                cw.op = OP_SQRT;     cw.cond = C_SQRT_RUN;    cw.target = PC_SQRT;
            end
            PC_CHECK: begin
                cw.op = OP_SET_D;    cw.cond = C_BELOW_TWO;   cw.target = PC_COMPOSITE;
            end
            PC_TEST_D: begin
                cw.op = OP_DIV_INIT; cw.cond = C_D_PAST_ROOT; cw.target = PC_PRIME;
            end
            PC_DIV: begin
                cw.op = OP_DIV;      cw.cond = C_DIV_RUN;     cw.target = PC_DIV;
            end
            PC_NEXT_D: begin
                cw.op = OP_NEXT_D;   cw.cond = C_REM_NZ;      cw.target = PC_TEST_D;
            end
            PC_COMPOSITE: begin
                cw.cond = C_ALWAYS;  cw.target = PC_IDLE;     cw.strobe = 1'b1;
            end
            PC_PRIME: begin
                cw.cond = C_ALWAYS;  cw.target = PC_IDLE;     cw.strobe = 1'b1;
                cw.prime = 1'b1;
            end
            default: begin
                cw.cond = C_ALWAYS;  cw.target = PC_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/trial_division_prime_test.sv =====
// Sequence: load, square-root steps, a below-two check, then per trial divisor a root
//   test, the restoring division steps and a remainder test, until one ends the search.
// Throughput: one number at a time; the restoring divider, run once per trial divisor,
//   sets the rate. The result strobe rises in the cycle busy falls.
// Reset: synchronous, active low; the sequencer returns to idle and no result is shown.
// The receiver cannot stall: o_valid lasts exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [31:0] i_value,
    output logic             busy,
    output logic             o_valid,
    output logic             o_is_prime
);

    // Sequencer state
    logic [PC_W-1:0]    r_pc, n_pc;
    logic               r_valid, r_prime;
    t_ctrl              cw;
    logic               cond_true;

    // Datapath registers
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_op;       // square-root residue
    logic [VALUE_W-1:0] r_res;      // square-root result
    logic [VALUE_W-1:0] r_bit;      // square-root weight
    logic [DIV_W-1:0]   r_div;      // trial divisor
    logic [DIV_W-1:0]   r_rem;      // partial remainder
    logic [VALUE_W-1:0] r_dvd;      // dividend shifter
    logic [CNT_W-1:0]   r_cnt;

    // Datapath arithmetic
    logic [VALUE_W:0]   sq_sum;
    logic               sq_take;
    logic [DIV_W:0]     dv_part;
    logic               dv_take;

    assign cw = ucode(r_pc);

    assign sq_sum  = {1'b0, r_res} + {1'b0, r_bit};
    assign sq_take = {1'b0, r_op} >= sq_sum;
    assign dv_part = {r_rem, r_dvd[VALUE_W-1]};
    assign dv_take = dv_part >= {1'b0, r_div};

    // Jump condition select
    always_comb begin
        case (cw.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_START:    cond_true = !start;
            C_SQRT_RUN:    cond_true = r_cnt != SQRT_LAST;
            C_BELOW_TWO:   cond_true = r_value < VALUE_W'(2);
            C_D_PAST_ROOT: cond_true = r_div > {1'b0, r_res[ROOT_W-1:0]};
            C_DIV_RUN:     cond_true = r_cnt != DIV_LAST;
            C_REM_NZ:      cond_true = r_rem != '0;
            default:       cond_true = 1'b0;
        endcase
        n_pc = cond_true ? cw.target : r_pc + PC_W'(1);
    end

    // Microprogram counter and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= cw.strobe;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_prime <= cw.prime;
        case (cw.op)
            OP_LOAD: begin
                r_value <= VALUE_W'(i_value);
                r_op    <= VALUE_W'(i_value);
                r_res   <= '0;
                r_bit   <= VALUE_W'(1) << (VALUE_W - 2);
                r_cnt   <= '0;
            end
            OP_SQRT: begin
                if (sq_take) begin
                    r_op  <= r_op - sq_sum[VALUE_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_SET_D: begin
                r_div <= FIRST_DIV;
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_dvd <= r_value;
                r_cnt <= '0;
            end
            OP_DIV: begin
                r_rem <= dv_take ? DIV_W'(dv_part - {1'b0, r_div}) : dv_part[DIV_W-1:0];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_NEXT_D: begin
                r_div <= r_div + DIV_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign busy       = r_pc != PC_IDLE;
    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;

endmodule

`default_nettype wire

// ===== hdl/tdpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic [31:0] i_value,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        o_is_prime
);

    // A transfer in starts the sequencer
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after input transfer");

    // Every finished search delivers its result
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("search ended without a result");

    // A result is shown only once the sequencer is back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe outside end of search");

    // Small numbers: zero and one are never reported prime
    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_value < 32'd2 |-> ##19 (o_valid && !o_is_prime))
        else $error("zero or one reported prime");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

// ===== dv/trial_division_prime_test_test.sv =====
`timescale 1ns / 1ps

module trial_division_prime_test_test;
    import tdpt_pkg::*;

    // Idle cycles allowed with no transfer and no result; the slowest item here is
    // a prime near 2^20
    localparam int IDLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS = 100;

    // Edge cases: below two, tiny primes, prime squares, 2^16 +/- 1, full-width patterns
    localparam logic [31:0] CORNER_VALUES [23] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
        32'd97, 32'd121, 32'd63001, 32'd65535, 32'd65536, 32'd65537, 32'd1000003,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h7FFF_FFFD
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [31:0] i_value;
    logic        busy;
    logic        o_valid;
    logic        o_is_prime;

    typedef struct {
        logic [VALUE_W-1:0] number;
        logic               prime;
    } t_verdict;

    // Primality predictor plus the queue of verdicts still owed by the block
    class prime_scoreboard;
        t_verdict verdict_q[$];
        int       failures = 0;

        function logic prime_of(logic [VALUE_W-1:0] n);
            logic [ROOT_W-1:0] root;
            logic [ROOT_W-1:0] probe;
            logic [DIV_W-1:0]  divisor;
            // floor square root, one bit at a time from the top
            root = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                probe = root | (ROOT_W'(1) << b);
                if (64'(probe) * 64'(probe) <= 64'(n))
                    root = probe;
            end
            if (n < 2)
                return 1'b0;
            // first divisor up to the root decides it
            for (divisor = FIRST_DIV; divisor <= DIV_W'(root); divisor++)
                if (n % VALUE_W'(divisor) == 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_number(logic [31:0] n);
            t_verdict v;
            v.number = VALUE_W'(n);
            v.prime  = prime_of(v.number);
            verdict_q.push_back(v);
        endfunction

        function void check_flag(logic actual);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: is_prime=%0b, no number outstanding", actual);
                return;
            end
            want = verdict_q.pop_front();
            if (actual !== want.prime) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: value=%0d expected is_prime=%0b got %0b",
                             want.number, want.prime, actual);
            end
        endfunction
    endclass

    prime_scoreboard books;
    int              idle_cycles;

    trial_division_prime_test uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_value    (i_value),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: every strobe is a transfer, the receiver cannot stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            books.check_flag(o_is_prime);
    end

    // Watchdog on cycles with neither an input transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[trial_division_prime_test] ERROR");
            $finish;
        end
    end

    // Present one number and hold it until the transfer; keep start high if
    // another number follows at once
    task automatic send_number(input logic [31:0] n, input bit hold);
        start   <= 1'b1;
        i_value <= n;
        do @(posedge i_clk); while (busy);
        books.note_number(n);
        if (!hold)
            start <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (books.verdict_q.size() != 0);
    endtask

    // Mostly small numbers keep the search short; full-width ones get a small factor
    function automatic logic [31:0] pick_number();
        int unsigned roll;
        int unsigned k;
        logic [31:0] n;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            n = $urandom_range(0, 15);
        end else if (roll < 60) begin
            n = $urandom_range(0, 16383);
        end else if (roll < 80) begin
            n = $urandom;
            k = $urandom_range(2, 7);
            n = n - n % k;
        end else if (roll < 90) begin
            n = $urandom_range(0, 1 << 20);
        end else begin
            n = $urandom_range(2, 300) * $urandom_range(2, 300);
        end
        return n;
    endfunction

    initial begin
        int  sent;
        int  burst;
        bit  tail_item;
        books   = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners back to back, then let everything drain
        foreach (CORNER_VALUES[i])
            send_number(CORNER_VALUES[i], i != $size(CORNER_VALUES) - 1);
        wait_drained();
        repeat ($urandom_range(1, 30)) @(posedge i_clk);

        // random bursts with random gaps, sometimes a full drain
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                tail_item = (k == burst - 1) || (sent == RANDOM_ITEMS - 1);
                send_number(pick_number(), !tail_item);
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            else
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (books.failures == 0 && books.verdict_q.size() == 0)
            $display("[trial_division_prime_test] OK");
        else
            $display("[trial_division_prime_test] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tdpt_pkg.sv
hdl/trial_division_prime_test.sv
hdl/tdpt_checker.sv
dv/trial_division_prime_test_test.sv
